// ===== src/evt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression value table package
// Shared constants, register codes and the token that travels the cell chain.
// ----------------------------------------------------------------------------
package evt_pkg;

	// Parameter defaults.
	localparam int TABLE_DEPTH_DEF  = 64;
	localparam int ID_WIDTH_DEF     = 16;
	localparam int OPCODE_WIDTH_DEF = 6;

	// Configuration register file.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_OP_W   = 6;
	localparam int MASK_W     = 64;
	localparam int MASK_IDX_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ELIG_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELIG_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMM_MASK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_OP   = 2'd3;

	// Progress of one lookup as it moves from cell to cell.
	typedef struct packed {
		logic valid;
		logic hit;
		logic done;
	} evt_tok_t;

endpackage
`default_nettype wire

// ===== src/evt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression value table channels
// Valid/ready channels for incoming instructions and rewritten results.
// ----------------------------------------------------------------------------
interface evt_instr_if #(
	parameter int ID_WIDTH     = evt_pkg::ID_WIDTH_DEF,
	parameter int OPCODE_WIDTH = evt_pkg::OPCODE_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic [OPCODE_WIDTH-1:0] opcode;
	logic [ID_WIDTH-1:0]     left_id;
	logic [ID_WIDTH-1:0]     right_id;
	logic [ID_WIDTH-1:0]     dest_id;
	logic                    last_of_pass;

	modport source (output valid, opcode, left_id, right_id, dest_id, last_of_pass,
		input ready);
	modport sink (input valid, opcode, left_id, right_id, dest_id, last_of_pass,
		output ready);
endinterface

interface evt_result_if #(
	parameter int ID_WIDTH     = evt_pkg::ID_WIDTH_DEF,
	parameter int OPCODE_WIDTH = evt_pkg::OPCODE_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic [OPCODE_WIDTH-1:0] out_opcode;
	logic [ID_WIDTH-1:0]     out_left;
	logic [ID_WIDTH-1:0]     out_right;
	logic                    was_replaced;
	logic                    table_full;

	modport source (output valid, out_opcode, out_left, out_right, was_replaced,
		table_full, input ready);
	modport sink (input valid, out_opcode, out_left, out_right, was_replaced,
		table_full, output ready);
endinterface
`default_nettype wire

// ===== src/evt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression value table cell
// Holds one table entry, compares it against the passing lookup and claims
// the lookup for insertion when the entry is still free.
// ----------------------------------------------------------------------------
module evt_cell #(
	parameter int ID_WIDTH     = evt_pkg::ID_WIDTH_DEF,
	parameter int OPCODE_WIDTH = evt_pkg::OPCODE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic [OPCODE_WIDTH-1:0] key_op,
	input  wire logic [ID_WIDTH-1:0]     key_left,
	input  wire logic [ID_WIDTH-1:0]     key_right,
	input  wire logic [ID_WIDTH-1:0]     key_dest,
	input  wire logic                    key_elig,
	input  wire logic                    key_last,
	input  wire evt_pkg::evt_tok_t       tok_i,
	input  wire logic [ID_WIDTH-1:0]     hval_i,
	output evt_pkg::evt_tok_t            tok_o,
	output logic [ID_WIDTH-1:0]          hval_o
);

	logic                    valid_q;
	logic [OPCODE_WIDTH-1:0] op_q;
	logic [ID_WIDTH-1:0]     left_q;
	logic [ID_WIDTH-1:0]     right_q;
	logic [ID_WIDTH-1:0]     value_q;

	logic              match;
	logic              ins;
	evt_pkg::evt_tok_t tok_nx;
	logic [ID_WIDTH-1:0] hval_nx;

	// Entries fill from the front, so the first free cell is reached only after
	// every occupied one has been compared.
	always_comb begin
		match   = valid_q && key_elig && !tok_i.hit && (op_q == key_op) &&
			(left_q == key_left) && (right_q == key_right);
		ins     = key_elig && !tok_i.hit && !tok_i.done && !valid_q;
		tok_nx  = tok_i;
		hval_nx = hval_i;
		if (match) begin
			tok_nx.hit = 1'b1;
			hval_nx    = value_q;
		end
		if (ins) begin
			tok_nx.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_o   <= '0;
		end else if (adv) begin
			tok_o <= tok_nx;
			if (tok_i.valid) begin
				if (key_last) begin
					valid_q <= 1'b0;
				end else if (ins) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hval_o <= hval_nx;
			if (tok_i.valid && ins) begin
				op_q    <= key_op;
				left_q  <= key_left;
				right_q <= key_right;
				value_q <= key_dest;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/expression_value_table.sv =====
`default_nettype none
// An accepted request is registered, then its lookup walks the row of entry cells
// one cell per cycle while the row is not stalled, and the result is registered
// at the output. The next request waits for the lookup to leave the row.
// A waiting result does not block the next request while the row is free.
// Reset clears all entries, the configuration registers and the handshake state.
// ----------------------------------------------------------------------------
// Expression value table
// Value table for common subexpression elimination, built as a row of cells.
// ----------------------------------------------------------------------------
module expression_value_table #(
	parameter int TABLE_DEPTH  = evt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_WIDTH     = evt_pkg::ID_WIDTH_DEF,
	parameter int OPCODE_WIDTH = evt_pkg::OPCODE_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [evt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [evt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	evt_instr_if.sink                             instr,
	evt_result_if.source                          result
);

	// Opcodes are compared against the configured range at a width that holds
	// both the opcode and the range registers.
	localparam int OPX_W = OPCODE_WIDTH + evt_pkg::CFG_OP_W;

	// Configuration registers.
	logic [evt_pkg::CFG_OP_W-1:0] elig_low_q;
	logic [evt_pkg::CFG_OP_W-1:0] elig_high_q;
	logic [evt_pkg::MASK_W-1:0]   comm_mask_q;
	logic [evt_pkg::CFG_OP_W-1:0] move_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_low_q  <= '0;
			elig_high_q <= '0;
			comm_mask_q <= '0;
			move_op_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				evt_pkg::REG_ELIG_LOW:  elig_low_q  <= cfg_wdata[evt_pkg::CFG_OP_W-1:0];
				evt_pkg::REG_ELIG_HIGH: elig_high_q <= cfg_wdata[evt_pkg::CFG_OP_W-1:0];
				evt_pkg::REG_COMM_MASK: comm_mask_q <= cfg_wdata[evt_pkg::MASK_W-1:0];
				evt_pkg::REG_MOVE_OP:   move_op_q   <= cfg_wdata[evt_pkg::CFG_OP_W-1:0];
				default: ;
			endcase
		end
	end

	// Request decode. The block works on one request at a time, so the decoded
	// key is held here and shown to every cell while the lookup walks the row.
	logic               busy_q;
	logic               launch_q;
	logic               accept;
	logic [OPX_W-1:0]   op_ext;
	logic               elig;
	logic               commute;
	logic               swap;

	assign instr.ready = !busy_q;
	assign accept      = instr.valid && !busy_q;

	always_comb begin
		op_ext  = OPX_W'(instr.opcode);
		elig    = (op_ext >= OPX_W'(elig_low_q)) && (op_ext <= OPX_W'(elig_high_q));
		// Opcodes beyond the mask have no commutative bit.
		commute = (op_ext < OPX_W'(evt_pkg::MASK_W)) &&
			comm_mask_q[op_ext[evt_pkg::MASK_IDX_W-1:0]];
		swap    = commute && (instr.left_id > instr.right_id);
	end

	logic [OPCODE_WIDTH-1:0] req_op_q;
	logic [ID_WIDTH-1:0]     req_left_q;
	logic [ID_WIDTH-1:0]     req_right_q;
	logic [ID_WIDTH-1:0]     key_left_q;
	logic [ID_WIDTH-1:0]     key_right_q;
	logic [ID_WIDTH-1:0]     dest_q;
	logic                    elig_q;
	logic                    last_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= instr.opcode;
			req_left_q  <= instr.left_id;
			req_right_q <= instr.right_id;
			key_left_q  <= swap ? instr.right_id : instr.left_id;
			key_right_q <= swap ? instr.left_id : instr.right_id;
			dest_q      <= instr.dest_id;
			elig_q      <= elig;
			last_q      <= instr.last_of_pass;
		end
	end

	// The row of cells. The token leaving the last cell carries whether some
	// entry matched (and its value) and whether a free cell took the key.
	evt_pkg::evt_tok_t   tok  [TABLE_DEPTH+1];
	logic [ID_WIDTH-1:0] hval [TABLE_DEPTH+1];
	logic                adv;
	logic                out_valid_q;

	// The whole row moves together; it stops only when the finished lookup
	// cannot enter the output register.
	assign adv = !(tok[TABLE_DEPTH].valid && out_valid_q && !result.ready);

	assign tok[0]  = '{valid: launch_q, hit: 1'b0, done: 1'b0};
	assign hval[0] = '0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		evt_cell #(
			.ID_WIDTH     (ID_WIDTH),
			.OPCODE_WIDTH (OPCODE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.key_op    (req_op_q),
			.key_left  (key_left_q),
			.key_right (key_right_q),
			.key_dest  (dest_q),
			.key_elig  (elig_q),
			.key_last  (last_q),
			.tok_i     (tok[k]),
			.hval_i    (hval[k]),
			.tok_o     (tok[k+1]),
			.hval_o    (hval[k+1])
		);
	end

	logic finish;
	assign finish = adv && tok[TABLE_DEPTH].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				launch_q <= 1'b1;
			end else begin
				if (adv) begin
					launch_q <= 1'b0;
				end
				if (finish) begin
					busy_q <= 1'b0;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register. A hit becomes a move of the stored value; an eligible miss
	// that found no free cell reports a full table.
	logic [OPCODE_WIDTH-1:0] o_op_q;
	logic [ID_WIDTH-1:0]     o_left_q;
	logic [ID_WIDTH-1:0]     o_right_q;
	logic                    o_hit_q;
	logic                    o_full_q;

	always_ff @(posedge clk) begin
		if (finish) begin
			o_hit_q  <= tok[TABLE_DEPTH].hit;
			o_full_q <= elig_q && !tok[TABLE_DEPTH].hit && !tok[TABLE_DEPTH].done;
			if (tok[TABLE_DEPTH].hit) begin
				o_op_q    <= OPCODE_WIDTH'(move_op_q);
				o_left_q  <= hval[TABLE_DEPTH];
				o_right_q <= '0;
			end else begin
				o_op_q    <= req_op_q;
				o_left_q  <= req_left_q;
				o_right_q <= req_right_q;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_opcode   = o_op_q;
	assign result.out_left     = o_left_q;
	assign result.out_right    = o_right_q;
	assign result.was_replaced = o_hit_q;
	assign result.table_full   = o_full_q;

`ifndef ASSERT_OFF
	// No lookup may be entering or leaving the row unless a request is outstanding.
	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!launch_q && !tok[TABLE_DEPTH].valid))
		else $error("lookup token present while block is idle");

	// A lookup either hits or inserts, never both.
	a_hit_or_insert: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_DEPTH].valid |-> !(tok[TABLE_DEPTH].hit && tok[TABLE_DEPTH].done))
		else $error("lookup both matched and inserted");

	// A finished lookup reaches the output register in the same step the
	// block becomes free again.
	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && !busy_q))
		else $error("finished lookup did not reach the output register");
`endif

endmodule
`default_nettype wire
